/* sv/lsfh_pkg.sv */
// lin slave frame handler: shared types, constants and helper functions
// no dependencies; used by every module of the block

package lsfh_pkg;

  // table geometry
  localparam int TableEntries = 8;
  localparam int MaxDataBytes = 8;
  localparam int IdW          = 6;
  localparam int EntryW       = 3;
  localparam int LenW         = 4;
  localparam int AddrW        = 3;
  localparam int TableIdsW    = IdW * 8;

  // input commands
  localparam logic [1:0] CMD_BREAK = 2'd0;
  localparam logic [1:0] CMD_BUS   = 2'd1;
  localparam logic [1:0] CMD_APP   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_RX   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // configuration register indexes
  localparam logic REG_TABLE_IDS = 1'b0;
  localparam logic REG_RX_MASK   = 1'b1;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // outcome of one identifier search
  typedef struct packed {
    logic              done;
    logic              found;
    logic [EntryW-1:0] entry;
  } srch_res_t;

  // classic checksum step: 8-bit add with end-around carry
  function automatic logic [7:0] add_carry(input logic [7:0] sum, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, sum} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  // parity of a protected identifier, id in bits 7..2, p1 in bit 1, p0 in bit 0
  function automatic logic parity_ok(input logic [7:0] pid);
    logic [IdW-1:0] id;
    logic           p0;
    logic           p1;
    id = pid[7:2];
    p0 = id[5] ^ id[4] ^ id[3] ^ id[1];
    p1 = ~(id[4] ^ id[2] ^ id[1] ^ id[0]);
    return (pid[1] == p1) && (pid[0] == p0);
  endfunction

  // data length from the two low id bits
  function automatic logic [LenW-1:0] frame_len(input logic [1:0] code);
    logic [LenW-1:0] len;
    unique case (code)
      2'd0, 2'd1: len = 4'd2;
      2'd2:       len = 4'd4;
      default:    len = 4'd8;
    endcase
    return len;
  endfunction

endpackage

/* sv/lsfh_id_search.sv */
// identifier search: one shared comparator walks the table one entry a cycle
// depends on lsfh_pkg

module lsfh_id_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lsfh_pkg::IdW-1:0]            id_i,
  input  logic [lsfh_pkg::TableIdsW-1:0]      table_ids,
  output lsfh_pkg::srch_res_t                 res
);

  localparam logic [lsfh_pkg::EntryW-1:0] LastEntry =
    lsfh_pkg::EntryW'(lsfh_pkg::TableEntries - 1);

  logic                          busy_r, busy_nxt;
  logic [lsfh_pkg::EntryW-1:0]   k_r, k_nxt;
  logic [lsfh_pkg::IdW-1:0]      id_r, id_nxt;
  logic                          match;

  // the shared compare
  assign match = (table_ids[lsfh_pkg::IdW * k_r +: lsfh_pkg::IdW] == id_r);

  always_comb begin
    busy_nxt  = busy_r;
    k_nxt     = k_r;
    id_nxt    = id_r;
    res.done  = 1'b0;
    res.found = 1'b0;
    res.entry = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      id_nxt   = id_i;
    end else if (busy_r) begin
      // first match wins, else stop after the last entry
      if (match || (k_r == LastEntry)) begin
        res.done  = 1'b1;
        res.found = match;
        busy_nxt  = 1'b0;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      id_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      id_r   <= id_nxt;
    end
  end

endmodule

/* sv/lsfh_data_buf.sv */
// receive data buffer: one write port, one registered read port
// depends on lsfh_pkg

module lsfh_data_buf (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lsfh_pkg::AddrW-1:0]  waddr,
  input  logic [7:0]                  wdata,
  input  logic [lsfh_pkg::AddrW-1:0]  raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [lsfh_pkg::MaxDataBytes];
  logic [7:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/lin_slave_frame_handler.sv */
// lin slave frame handler top level: frame sequencer, checksum and result register
// depends on lsfh_pkg, lsfh_id_search and lsfh_data_buf
//
//  channel  direction  fields
//  in_      slave      tuser: cmd, tdata: data_byte
//  out_     master     tuser: kind, tlast: last, tdata: value, entry, frame_id, length
//  cfg_     write      index 0 table_ids, index 1 table_receive_mask
//
// break, sync, received data and ignored transfers are taken in ST_IDLE; a protected
// identifier with good parity runs the shared id comparator, then a response request
// for a transmit entry; a transmit byte passes ST_EMIT_TX, the final one ST_EMIT_TXA
// and ST_EMIT_CS with the checksum; a checksum byte passes ST_FETCH and ST_EMIT_RX per
// delivered byte through the buffer's registered read port, or ST_EMIT_ERR on error.
// in_tready is low while a step is busy; reset is synchronous and active low, and a
// stalled result holds in the output register and holds the sequencer until taken.

module lin_slave_frame_handler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // data_byte[7:0]
  input  logic [1:0]                          in_tuser,   // cmd[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // value[7:0], entry[10:8],
                                                          // frame_id[16:11], length[20:17]
  output logic [1:0]                          out_tuser,  // kind[1:0]
  output logic                                out_tlast,  // last
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [lsfh_pkg::TableIdsW-1:0]      cfg_wdata
);

  // frame phases
  localparam logic [2:0] PH_WAIT_BREAK = 3'd0;
  localparam logic [2:0] PH_SYNC       = 3'd1;
  localparam logic [2:0] PH_PID        = 3'd2;
  localparam logic [2:0] PH_RX_DATA    = 3'd3;
  localparam logic [2:0] PH_RX_CHECK   = 3'd4;
  localparam logic [2:0] PH_TX_DATA    = 3'd5;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEARCH   = 4'd1;
  localparam logic [3:0] ST_EMIT_REQ = 4'd2;
  localparam logic [3:0] ST_EMIT_TX  = 4'd3;
  localparam logic [3:0] ST_EMIT_TXA = 4'd4;
  localparam logic [3:0] ST_EMIT_CS  = 4'd5;
  localparam logic [3:0] ST_FETCH    = 4'd6;
  localparam logic [3:0] ST_EMIT_RX  = 4'd7;
  localparam logic [3:0] ST_EMIT_ERR = 4'd8;

  // configuration registers
  logic [lsfh_pkg::TableIdsW-1:0] table_ids_r;
  logic [7:0]                     rx_mask_r;

  // frame state
  logic [3:0]                    state_r, state_nxt;
  logic [2:0]                    phase_r, phase_nxt;
  logic [lsfh_pkg::IdW-1:0]      cur_id_r, cur_id_nxt;
  logic [lsfh_pkg::EntryW-1:0]   cur_entry_r, cur_entry_nxt;
  logic [lsfh_pkg::LenW-1:0]     len_r, len_nxt;
  logic [lsfh_pkg::LenW-1:0]     cnt_r, cnt_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic [lsfh_pkg::AddrW-1:0]    idx_r, idx_nxt;

  // result register
  logic                          out_valid_r;
  logic [1:0]                    out_kind_r;
  logic [7:0]                    out_value_r;
  logic [lsfh_pkg::EntryW-1:0]   out_entry_r;
  logic [lsfh_pkg::IdW-1:0]      out_id_r;
  logic [lsfh_pkg::LenW-1:0]     out_len_r;
  logic                          out_last_r;

  logic                          emit;
  logic [1:0]                    emit_kind;
  logic [7:0]                    emit_value;
  logic                          emit_last;

  logic                          accept;
  logic                          slot_free;
  logic                          srch_start;
  logic                          buf_we;
  logic [7:0]                    rd_data;
  logic [7:0]                    sum_step;
  logic [lsfh_pkg::LenW-1:0]     cnt_inc;
  lsfh_pkg::srch_res_t           srch;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign sum_step  = lsfh_pkg::add_carry(sum_r, in_tdata);
  assign cnt_inc   = cnt_r + 1'b1;

  assign srch_start = accept && (in_tuser == lsfh_pkg::CMD_BUS) && (phase_r == PH_PID)
                      && lsfh_pkg::parity_ok(in_tdata);
  assign buf_we     = accept && (in_tuser == lsfh_pkg::CMD_BUS) && (phase_r == PH_RX_DATA);

  lsfh_id_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (srch_start),
    .id_i      (in_tdata[7:2]),
    .table_ids (table_ids_r),
    .res       (srch)
  );

  lsfh_data_buf u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cnt_r[lsfh_pkg::AddrW-1:0]),
    .wdata (in_tdata),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_ids_r <= '0;
      rx_mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsfh_pkg::REG_TABLE_IDS: table_ids_r <= cfg_wdata;
        lsfh_pkg::REG_RX_MASK:   rx_mask_r   <= cfg_wdata[7:0];
        default:                 table_ids_r <= table_ids_r;
      endcase
    end
  end

  // frame sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cur_id_nxt    = cur_id_r;
    cur_entry_nxt = cur_entry_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    byte_nxt      = byte_r;
    idx_nxt       = idx_r;
    emit          = 1'b0;
    emit_kind     = lsfh_pkg::KIND_REQ;
    emit_value    = 8'd0;
    emit_last     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == lsfh_pkg::CMD_BREAK) begin
            phase_nxt = PH_SYNC;
          end else begin
            unique case (phase_r)
              PH_SYNC: begin
                if (in_tuser == lsfh_pkg::CMD_BUS) begin
                  phase_nxt = (in_tdata == lsfh_pkg::SYNC_BYTE) ? PH_PID : PH_WAIT_BREAK;
                end
              end
              PH_PID: begin
                if (in_tuser == lsfh_pkg::CMD_BUS) begin
                  phase_nxt = PH_WAIT_BREAK;
                  if (srch_start) begin
                    state_nxt = ST_SEARCH;
                  end
                end
              end
              PH_RX_DATA: begin
                if (in_tuser == lsfh_pkg::CMD_BUS) begin
                  sum_nxt = sum_step;
                  cnt_nxt = cnt_inc;
                  if (cnt_inc >= len_r) begin
                    phase_nxt = PH_RX_CHECK;
                  end
                end
              end
              PH_RX_CHECK: begin
                if (in_tuser == lsfh_pkg::CMD_BUS) begin
                  phase_nxt = PH_WAIT_BREAK;
                  idx_nxt   = '0;
                  state_nxt = (in_tdata == ~sum_r) ? ST_FETCH : ST_EMIT_ERR;
                end
              end
              PH_TX_DATA: begin
                if (in_tuser == lsfh_pkg::CMD_APP) begin
                  sum_nxt  = sum_step;
                  cnt_nxt  = cnt_inc;
                  byte_nxt = in_tdata;
                  if (cnt_inc >= len_r) begin
                    phase_nxt = PH_WAIT_BREAK;
                    state_nxt = ST_EMIT_TXA;
                  end else begin
                    state_nxt = ST_EMIT_TX;
                  end
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end
        end
      end
      ST_SEARCH: begin
        if (srch.done) begin
          if (srch.found) begin
            // identifier of a found frame, held in byte_r since the pid transfer
            cur_id_nxt    = byte_r[7:2];
            cur_entry_nxt = srch.entry;
            cnt_nxt       = '0;
            sum_nxt       = '0;
            if (rx_mask_r[srch.entry]) begin
              phase_nxt = PH_RX_DATA;
              state_nxt = ST_IDLE;
            end else begin
              phase_nxt = PH_TX_DATA;
              state_nxt = ST_EMIT_REQ;
            end
            len_nxt = lsfh_pkg::frame_len(cur_id_nxt[1:0]);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_REQ: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_TX: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = lsfh_pkg::KIND_TX;
          emit_value = byte_r;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT_TXA: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = lsfh_pkg::KIND_TX;
          emit_value = byte_r;
          emit_last  = 1'b0;
          state_nxt  = ST_EMIT_CS;
        end
      end
      ST_EMIT_CS: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = lsfh_pkg::KIND_TX;
          emit_value = ~sum_r;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT_RX;
      end
      ST_EMIT_RX: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = lsfh_pkg::KIND_RX;
          emit_value = rd_data;
          emit_last  = (({1'b0, idx_r} + 1'b1) == len_r);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_EMIT_ERR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = lsfh_pkg::KIND_ERR;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer registers; the pid byte is kept in byte_r while the search runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_WAIT_BREAK;
      cur_id_r    <= '0;
      cur_entry_r <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      byte_r      <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cur_id_r    <= cur_id_nxt;
      cur_entry_r <= cur_entry_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      byte_r      <= srch_start ? in_tdata : byte_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= emit_kind;
      out_value_r <= emit_value;
      out_last_r  <= emit_last;
      out_entry_r <= cur_entry_r;
      out_id_r    <= cur_id_r;
      out_len_r   <= len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_len_r, out_id_r, out_entry_r, out_value_r};

endmodule
